// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by rcv_engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/rcv_pkg.sv
// ----------------------------------------------------------------------------
// rcv_pkg
// shared types, constants and helpers of the rc4 variant stream cipher
// ----------------------------------------------------------------------------
package rcv_pkg;

   localparam int BYTE_W     = 8;
   localparam int BOX_DEPTH  = 256;
   localparam int KEY_BYTES  = 16;
   localparam int KEY_IDX_W  = 4;
   localparam int KEY_LEN_W  = 5;
   localparam int KEY_W      = KEY_BYTES * BYTE_W;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [KEY_LEN_W-1:0] length;
   } key_cfg_type;

   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [BYTE_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic [BYTE_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [KEY_IDX_W-1:0] idx);
      key_byte = key[{idx, 3'b000} +: BYTE_W];
   endfunction

endpackage

// File: rtl/rcv_csr.sv
// ----------------------------------------------------------------------------
// rcv_csr
// apb register file holding the key and the key length
// ----------------------------------------------------------------------------
module rcv_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output rcv_pkg::key_cfg_type               key_cfg
);

   logic [rcv_pkg::CSR_DATA_W-1:0] key_low_ff, key_low_in;
   logic [rcv_pkg::CSR_DATA_W-1:0] key_high_ff, key_high_in;
   logic [rcv_pkg::KEY_LEN_W-1:0]  key_len_ff, key_len_in;
   logic [rcv_pkg::REG_IDX_W-1:0]  reg_idx;
   logic                           wr_fire;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rcv_pkg::CSR_ADDR_W-1:3];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            rcv_pkg::REG_KEY_LOW:    key_low_in  = csr_pwdata;
            rcv_pkg::REG_KEY_HIGH:   key_high_in = csr_pwdata;
            rcv_pkg::REG_KEY_LENGTH: key_len_in  = csr_pwdata[rcv_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rcv_pkg::REG_KEY_LOW:    csr_prdata = key_low_ff;
         rcv_pkg::REG_KEY_HIGH:   csr_prdata = key_high_ff;
         rcv_pkg::REG_KEY_LENGTH: csr_prdata = {{(rcv_pkg::CSR_DATA_W-rcv_pkg::KEY_LEN_W){1'b0}},
                                                key_len_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= rcv_pkg::KEY_LEN_RESET;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
      end
   end

   assign key_cfg.key    = {key_high_ff, key_low_ff};
   assign key_cfg.length = key_len_ff;

endmodule

// File: rtl/rcv_box_mem.sv
// ----------------------------------------------------------------------------
// rcv_box_mem
// 256 x 8 permutation memory, one write and one registered read per cycle;
// entries not written since the last clear or reset read as their own index
// ----------------------------------------------------------------------------
module rcv_box_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  rcv_pkg::mem_req_type          mem_req,
   output logic [rcv_pkg::BYTE_W-1:0]    rd_val
);

   logic [rcv_pkg::BYTE_W-1:0]    ram_ff [rcv_pkg::BOX_DEPTH];
   logic [rcv_pkg::BOX_DEPTH-1:0] valid_ff;
   logic [rcv_pkg::BYTE_W-1:0]    rdata_ff;
   logic [rcv_pkg::BYTE_W-1:0]    raddr_ff;
   logic                          rvalid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ram_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rdata_ff <= ram_ff[mem_req.rd_addr];
      raddr_ff <= mem_req.rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[mem_req.rd_addr];
         if (mem_req.clear) begin
            valid_ff <= '0;
         end else if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_val = rvalid_ff ? rdata_ff : raddr_ff;

endmodule

// File: rtl/rcv_engine.sv
// ----------------------------------------------------------------------------
// rcv_engine
// sequencer for the key schedule and the per-byte swap and keystream lookup
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcv_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rcv_pkg::BYTE_W-1:0]    req_data,
   input  logic                          req_first,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rcv_pkg::BYTE_W-1:0]    rsp_data,
   input  rcv_pkg::key_cfg_type          key_cfg,
   output rcv_pkg::mem_req_type          mem_req,
   input  logic [rcv_pkg::BYTE_W-1:0]    rd_val
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_K_RDN = 4'd1;
   localparam logic [3:0] ST_K_RDA = 4'd2;
   localparam logic [3:0] ST_K_W1  = 4'd3;
   localparam logic [3:0] ST_K_W2  = 4'd4;
   localparam logic [3:0] ST_RD_I  = 4'd5;
   localparam logic [3:0] ST_RD_J  = 4'd6;
   localparam logic [3:0] ST_SWAP1 = 4'd7;
   localparam logic [3:0] ST_SWAP2 = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [rcv_pkg::BYTE_W-1:0]    i_ff, i_in;
   logic [rcv_pkg::BYTE_W-1:0]    j_ff, j_in;
   logic [rcv_pkg::BYTE_W-1:0]    n_ff, n_in;
   logic [rcv_pkg::BYTE_W-1:0]    acc_ff, acc_in;
   logic [rcv_pkg::KEY_IDX_W-1:0] kidx_ff, kidx_in;
   logic [rcv_pkg::BYTE_W-1:0]    a_ff, a_in;
   logic [rcv_pkg::BYTE_W-1:0]    b_ff, b_in;
   logic [rcv_pkg::BYTE_W-1:0]    t_ff, t_in;
   logic [rcv_pkg::BYTE_W-1:0]    data_ff, data_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rcv_pkg::BYTE_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          rsp_free;
   logic [rcv_pkg::KEY_LEN_W-1:0] len_eff;
   logic [rcv_pkg::KEY_LEN_W-1:0] len_m1;
   logic [rcv_pkg::BYTE_W-1:0]    ks;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // zero or oversize length means the full key
   assign len_eff = ((key_cfg.length == '0) ||
                     (key_cfg.length > rcv_pkg::KEY_LEN_W'(rcv_pkg::KEY_BYTES)))
                    ? rcv_pkg::KEY_LEN_W'(rcv_pkg::KEY_BYTES) : key_cfg.length;
   assign len_m1  = len_eff - 5'd1;

   // forwarding of the swapped pair over the memory value
   assign ks = (t_ff == j_ff) ? a_ff : ((t_ff == i_ff) ? b_ff : rd_val);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      kidx_in      = kidx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               data_in = req_data;
               if (req_first) begin
                  mem_req.clear = 1'b1;
                  n_in          = '0;
                  acc_in        = '0;
                  kidx_in       = '0;
                  i_in          = '0;
                  j_in          = '0;
                  state_in      = ST_K_RDN;
               end else begin
                  state_in = ST_RD_I;
               end
            end
         end
         ST_K_RDN: begin
            mem_req.rd_addr = n_ff;
            state_in        = ST_K_RDA;
         end
         ST_K_RDA: begin
            a_in            = rd_val;
            acc_in          = acc_ff + rd_val + rcv_pkg::key_byte(key_cfg.key, kidx_ff);
            mem_req.rd_addr = acc_in;
            kidx_in         = (kidx_ff == len_m1[rcv_pkg::KEY_IDX_W-1:0])
                              ? '0 : kidx_ff + 4'd1;
            state_in        = ST_K_W1;
         end
         ST_K_W1: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = n_ff;
            mem_req.wr_data = rd_val;
            state_in        = ST_K_W2;
         end
         ST_K_W2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = acc_ff;
            mem_req.wr_data = a_ff;
            n_in            = n_ff + 8'd1;
            state_in        = (n_ff == 8'hff) ? ST_RD_I : ST_K_RDN;
         end
         ST_RD_I: begin
            i_in            = i_ff - 8'd1;
            mem_req.rd_addr = i_in;
            state_in        = ST_RD_J;
         end
         ST_RD_J: begin
            a_in            = rd_val;
            j_in            = j_ff + rd_val;
            mem_req.rd_addr = j_in;
            state_in        = ST_SWAP1;
         end
         ST_SWAP1: begin
            b_in            = rd_val;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff;
            mem_req.wr_data = rd_val;
            t_in            = a_ff + rd_val;
            mem_req.rd_addr = t_in;
            state_in        = ST_SWAP2;
         end
         ST_SWAP2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = a_ff;
            mem_req.rd_addr = t_ff;
            if (rsp_free) begin
               rsp_data_in  = ~(data_ff ^ ks);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         acc_ff       <= '0;
         kidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         kidx_ff      <= kidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_NEXT(a_first_starts_schedule, clock, reset, req_fire && req_first,
                (state_ff == ST_K_RDN) && (n_ff == '0) && (i_ff == '0) && (j_ff == '0))
   `ASSERT_NEXT(a_plain_starts_stream, clock, reset, req_fire && !req_first,
                state_ff == ST_RD_I)
   `ASSERT_NEXT(a_rsp_only_from_swap, clock, reset,
                !rsp_valid_ff && (state_ff != ST_SWAP2), !rsp_valid_ff)

endmodule

// File: rtl/rc4_variant_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_variant_stream_cipher
// byte stream cipher on a modified rc4 with a configurable key
//
//   port group   direction   contents
//   req_         in          tdata: data_in[7:0]; tuser: first
//   rsp_         out         tdata: data_out[7:0]
//   csr_         in/out      apb, 64-bit regs at 0x00, 0x08, 0x10
//
// a byte without first is accepted, then takes four steps on the single
// read and single write port of the permutation memory
// a byte with first adds the key schedule, two reads and two writes per entry, over all 256 entries
// reset restores the identity permutation at once through per-entry valid bits
// a stalled response holds the engine in its last step; one response register
// ----------------------------------------------------------------------------
module rc4_variant_stream_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rcv_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] data_in
   input  logic                               req_tuser,   // [0] first
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rcv_pkg::BYTE_W-1:0]         rsp_tdata,   // [7:0] data_out
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   rcv_pkg::key_cfg_type          key_cfg;
   rcv_pkg::mem_req_type          mem_req;
   logic [rcv_pkg::BYTE_W-1:0]    rd_val;

   rcv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_cfg     (key_cfg)
   );

   rcv_box_mem u_box_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_val  (rd_val)
   );

   rcv_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata),
      .req_first  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .key_cfg    (key_cfg),
      .mem_req    (mem_req),
      .rd_val     (rd_val)
   );

endmodule
